@@ hdl/can_multiframe_parameter_transfer_core_assert.svh @@
// Assertion macros for the parameter transfer core.
`ifndef CAN_MULTIFRAME_PARAMETER_TRANSFER_CORE_ASSERT_SVH
`define CAN_MULTIFRAME_PARAMETER_TRANSFER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CMPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cmpt assertion failed");

// Next-cycle implication, checked outside reset.
`define CMPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cmpt assertion failed");

`endif

@@ hdl/cmpt_pkg.sv @@
`default_nettype none
package cmpt_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int NUM_BLOCKS  = 3;
    localparam int STORE_BYTES = BLOCK_BYTES * NUM_BLOCKS;
    localparam int SA_W        = $clog2(STORE_BYTES);
    localparam int BOFF_W      = $clog2(BLOCK_BYTES);
    localparam int BREM        = BLOCK_BYTES % 8;
    localparam int NFR         = (BREM != 0) ? BLOCK_BYTES / 8 : BLOCK_BYTES / 8 - 1;
    localparam int END_LEN     = (BREM != 0) ? BREM : 8;
    localparam int KI_W        = $clog2(NFR + 1);
    localparam int OFF_W       = 20;

    localparam logic [15:0] BLK_BASE = 16'h6010;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_START = 3'd4;
    localparam logic [2:0] OP_XFER  = 3'd5;
    localparam logic [2:0] OP_END   = 3'd6;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam int          CFG_IDX_W = 1;
    localparam logic [0:0]  CFG_OWN   = 1'b0;
    localparam logic [0:0]  CFG_TOOL  = 1'b1;

    localparam logic [4:0] OWN_RESET  = 5'd2;
    localparam logic [4:0] TOOL_RESET = 5'd5;

    typedef struct packed {
        logic            we;
        logic [SA_W-1:0] waddr;
        logic [7:0]      wdata;
        logic            re;
        logic [SA_W-1:0] raddr;
    } t_st_req;

endpackage
`default_nettype wire

@@ hdl/cmpt_store.sv @@
`default_nettype none
module cmpt_store
    import cmpt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_st_req i_req,
    output logic [7:0]   o_rdata
);

    logic [7:0]             r_mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] r_vld;
    logic [7:0]             r_rdata;
    logic                   r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvld <= r_vld[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : 8'h00;

endmodule
`default_nettype wire

@@ hdl/can_multiframe_parameter_transfer_core.sv @@
// Channel   Direction  tdata (low bit up)                       tuser / tlast
// s_axis    in         frame_id[28:0] frame_len[32:29]          -
//                      frame_data[96:33], zero pad to 104
// m_axis    out        tx_id[28:0] tx_len[32:29]                kind[1:0] / last
//                      tx_data[96:33], zero pad to 104
// cfg       in         i_cfg_idx 0 own_address, 1 tool_address, 5-bit data
//
// One frame at a time; the store is a byte wide, so payload moves a byte a cycle.
// An end frame also waits for the output to take its status reply.
// A block read sends a start frame, then data frames and a final end frame.
// Reset is synchronous, active low; the byte store reads zero until written.
// A stalled output holds the engine; a new frame is taken once the engine is idle.
`default_nettype none
`include "can_multiframe_parameter_transfer_core_assert.svh"
module can_multiframe_parameter_transfer_core
    import cmpt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [103:0]         s_axis_tdata,  // frame_id, frame_len, frame_data
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [103:0]              m_axis_tdata,  // tx_id, tx_len, tx_data
    output logic [1:0]                m_axis_tuser,  // kind
    output logic                      m_axis_tlast,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [4:0]           i_cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DISP   = 3'd1;
    localparam logic [2:0] S_WR     = 3'd2;
    localparam logic [2:0] S_STAT   = 3'd3;
    localparam logic [2:0] S_RSTART = 3'd4;
    localparam logic [2:0] S_RBYTE  = 3'd5;
    localparam logic [2:0] S_ROUT   = 3'd6;

    logic [2:0]       r_state;
    logic [4:0]       r_own;
    logic [4:0]       r_tool;
    logic [15:0]      r_act;
    logic [7:0]       r_exp;

    logic [28:0]      r_id;
    logic [3:0]       r_len;
    logic [63:0]      r_data;
    logic [3:0]       r_cnt;
    logic [OFF_W-1:0] r_off;
    logic [SA_W-1:0]  r_base;
    logic             r_blk_ok;
    logic             r_is_end;
    logic             r_ok;
    logic [KI_W-1:0]  r_kidx;
    logic             r_rpend;

    logic             r_ov;
    logic [1:0]       r_okind;
    logic [28:0]      r_oid;
    logic [3:0]       r_olen;
    logic [63:0]      r_odata;
    logic             r_olast;

    logic [15:0]      cmd;
    logic [2:0]       op;
    logic [4:0]       tgt;
    logic [4:0]       src;
    logic [15:0]      bcmd;
    logic [15:0]      bdiff;
    logic             bvalid;
    logic [OFF_W-1:0] xoff;
    logic             out_free;
    logic             ov_load;
    logic             rd_end;
    logic [3:0]       flen;
    logic             rd_issue;
    logic [SA_W-1:0]  st_addr;
    logic [3:0]       in_len;
    logic [7:0]       st_rdata;
    t_st_req          st_req;

    assign cmd = r_id[15:0];
    assign op  = r_id[18:16];
    assign tgt = r_id[23:19];
    assign src = r_id[28:24];

    assign bcmd   = (op == OP_READ) ? cmd : r_act;
    assign bdiff  = bcmd - BLK_BASE;
    assign bvalid = (bcmd >= BLK_BASE) && (bdiff < 16'(NUM_BLOCKS));
    assign xoff   = {17'(cmd) + 17'd1, 3'b000};

    assign out_free = !r_ov || m_axis_tready;
    assign ov_load  = out_free && ((r_state == S_STAT) || (r_state == S_RSTART)
                                   || (r_state == S_ROUT));
    assign rd_end   = (r_kidx == KI_W'(NFR));
    assign flen     = rd_end ? 4'(END_LEN) : 4'd8;
    assign rd_issue = (r_state == S_RBYTE) && (r_cnt < 4'd8) && (r_cnt < flen);
    assign st_addr  = r_base + SA_W'(r_off[BOFF_W-1:0]);
    assign in_len   = (s_axis_tdata[32:29] > 4'd8) ? 4'd8 : s_axis_tdata[32:29];

    always_comb begin
        st_req.we    = (r_state == S_WR) && r_blk_ok && (r_cnt < r_len)
                       && (r_off < OFF_W'(BLOCK_BYTES));
        st_req.waddr = st_addr;
        st_req.wdata = r_data[7:0];
        st_req.re    = rd_issue;
        st_req.raddr = st_addr;
    end

    cmpt_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (st_req),
        .o_rdata (st_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own  <= OWN_RESET;
            r_tool <= TOOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OWN:  r_own  <= i_cfg_data;
                CFG_TOOL: r_tool <= i_cfg_data;
                default:  r_own  <= r_own;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= '0;
            r_exp   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (ov_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_id    <= s_axis_tdata[28:0];
                        r_len   <= in_len;
                        r_data  <= s_axis_tdata[96:33];
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_cnt    <= '0;
                    r_base   <= SA_W'(32'(bdiff) * BLOCK_BYTES);
                    r_blk_ok <= bvalid;
                    r_is_end <= (op == OP_END);
                    r_ok     <= (xoff + OFF_W'(r_len)) == OFF_W'(r_exp);
                    r_off    <= (op == OP_START) ? '0 : xoff;
                    if (tgt == r_own) begin
                        priority if (op == OP_WRITE) begin
                            if (r_len == 4'd1 && r_data[7:0] > 8'd8 && src == r_tool) begin
                                r_act <= cmd;
                                r_exp <= r_data[7:0];
                            end
                            r_state <= S_IDLE;
                        end else if (op == OP_READ) begin
                            r_state <= bvalid ? S_RSTART : S_IDLE;
                        end else if (op == OP_START || op == OP_XFER || op == OP_END) begin
                            r_state <= S_WR;
                            if (op == OP_END) begin
                                r_act <= '0;
                                r_exp <= '0;
                            end
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_WR: begin
                    r_data <= {8'h00, r_data[63:8]};
                    r_off  <= r_off + OFF_W'(1);
                    r_cnt  <= r_cnt + 4'd1;
                    if (r_cnt == 4'd7) begin
                        r_state <= r_is_end ? S_STAT : S_IDLE;
                    end
                end
                S_STAT: begin
                    if (out_free) begin
                        r_okind <= r_ok ? KIND_OK : KIND_FAIL;
                        r_oid   <= '0;
                        r_olen  <= '0;
                        r_odata <= '0;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_RSTART: begin
                    if (out_free) begin
                        r_okind <= KIND_TX;
                        r_oid   <= {r_own, r_tool, OP_START, cmd};
                        r_olen  <= 4'd1;
                        r_odata <= 64'(BLOCK_BYTES % 256);
                        r_olast <= 1'b0;
                        r_kidx  <= '0;
                        r_off   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_RBYTE;
                    end
                end
                S_RBYTE: begin
                    r_rpend <= rd_issue;
                    if (rd_issue) begin
                        r_off <= r_off + OFF_W'(1);
                    end
                    if (r_cnt != 4'd0) begin
                        r_data <= {(r_rpend ? st_rdata : 8'h00), r_data[63:8]};
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd8) begin
                        r_state <= S_ROUT;
                    end
                end
                S_ROUT: begin
                    if (out_free) begin
                        r_okind <= KIND_TX;
                        r_oid   <= {r_own, r_tool, rd_end ? OP_END : OP_XFER, 16'(r_kidx)};
                        r_olen  <= flen;
                        r_odata <= r_data;
                        r_olast <= rd_end;
                        r_kidx  <= r_kidx + KI_W'(1);
                        r_cnt   <= '0;
                        r_state <= rd_end ? S_IDLE : S_RBYTE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'b0, r_odata, r_olen, r_oid};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    `CMPT_ASSERT_NEXT(a_accept_decode, s_axis_tvalid && s_axis_tready, r_state == S_DISP)
    `CMPT_ASSERT_NOW(a_write_in_range, st_req.we, 32'(st_req.waddr) < STORE_BYTES)
    `CMPT_ASSERT_NOW(a_status_is_last, r_ov && r_okind != KIND_TX, r_olast)

endmodule
`default_nettype wire

@@ tb/tb_can_multiframe_parameter_transfer_core.sv @@
`timescale 1ns / 100ps
module tb_can_multiframe_parameter_transfer_core;
    import cmpt_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int RD_DATA_FRAMES = (BLOCK_BYTES % 8 != 0) ? BLOCK_BYTES / 8 : BLOCK_BYTES / 8 - 1;
    localparam int RD_END_LEN     = (BLOCK_BYTES % 8 != 0) ? BLOCK_BYTES % 8 : 8;

    typedef struct packed {
        logic [28:0] id;
        logic [3:0]  len;
        logic [63:0] data;
    } can_frame_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [28:0] id;
        logic [3:0]  len;
        logic [63:0] data;
        logic        last;
    } reply_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [103:0]         s_axis_tdata = '0;   // frame_id, frame_len, frame_data
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [103:0]         m_axis_tdata;        // tx_id, tx_len, tx_data
    logic [1:0]           m_axis_tuser;        // kind
    logic                 m_axis_tlast;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [4:0]           i_cfg_data = '0;

    can_frame_t pending_frames[$];
    reply_t     expected_replies[$];
    can_frame_t frame_on_bus;
    reply_t     head_reply;

    logic [7:0]  param_mem [BLOCK_BYTES*NUM_BLOCKS];
    logic [15:0] xfer_cmd = '0;
    logic [7:0]  xfer_len = '0;
    logic [4:0]  own_addr = OWN_RESET;
    logic [4:0]  tool_addr = TOOL_RESET;

    int send_idle_pct = 36;
    int recv_idle_pct = 86;
    int frames_queued = 0;
    int frames_accepted = 0;
    int mismatches = 0;
    int cycle_count = 0;

    can_multiframe_parameter_transfer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int block_index(logic [15:0] cmd);
        if (cmd >= BLK_BASE && int'(cmd - BLK_BASE) < NUM_BLOCKS)
            return int'(cmd - BLK_BASE);
        return -1;
    endfunction

    function automatic logic [63:0] block_bytes(int blk, int off, int n);
        logic [63:0] v;
        int i;
        v = '0;
        for (i = 0; i < n; i++)
            if (off + i < BLOCK_BYTES)
                v[8*i +: 8] = param_mem[blk*BLOCK_BYTES + off + i];
        return v;
    endfunction

    function automatic logic [28:0] reply_id(logic [15:0] cmd, logic [2:0] op);
        return {own_addr, tool_addr, op, cmd};
    endfunction

    function automatic void queue_reply(logic [1:0] kind, logic [28:0] id, logic [3:0] len,
                                        logic [63:0] data, logic last);
        expected_replies.push_back('{kind, id, len, data, last});
    endfunction

    function automatic void compute_replies(can_frame_t f);
        logic [15:0] cmd;
        logic [2:0]  op;
        logic [4:0]  tgt;
        logic [4:0]  src;
        int          n;
        int          blk;
        int          off;
        int          k;
        bit          ok;
        cmd = f.id[15:0];
        op  = f.id[18:16];
        tgt = f.id[23:19];
        src = f.id[28:24];
        n   = (f.len > 4'd8) ? 8 : int'(f.len);
        if (tgt != own_addr)
            return;
        case (op)
            OP_WRITE: begin
                if (n == 1 && f.data[7:0] > 8'd8 && src == tool_addr) begin
                    xfer_cmd = cmd;
                    xfer_len = f.data[7:0];
                end
            end
            OP_READ: begin
                blk = block_index(cmd);
                if (blk >= 0) begin
                    queue_reply(KIND_TX, reply_id(cmd, OP_START), 4'd1,
                                64'(BLOCK_BYTES % 256), 1'b0);
                    for (k = 0; k < RD_DATA_FRAMES; k++)
                        queue_reply(KIND_TX, reply_id(16'(k), OP_XFER), 4'd8,
                                    block_bytes(blk, k*8, 8), 1'b0);
                    queue_reply(KIND_TX, reply_id(16'(RD_DATA_FRAMES), OP_END), 4'(RD_END_LEN),
                                block_bytes(blk, RD_DATA_FRAMES*8, RD_END_LEN), 1'b1);
                end
            end
            OP_START, OP_XFER, OP_END: begin
                off = (op == OP_START) ? 0 : (int'(cmd) + 1) * 8;
                blk = block_index(xfer_cmd);
                if (blk >= 0)
                    for (k = 0; k < n; k++)
                        if (off + k < BLOCK_BYTES)
                            param_mem[blk*BLOCK_BYTES + off + k] = f.data[8*k +: 8];
                if (op == OP_END) begin
                    ok = ((int'(cmd) + 1) * 8 + n) == int'(xfer_len);
                    xfer_cmd = '0;
                    xfer_len = '0;
                    queue_reply(ok ? KIND_OK : KIND_FAIL, '0, '0, '0, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                compute_replies(frame_on_bus);
                frames_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_frames.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    frame_on_bus = pending_frames.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, frame_on_bus.data, frame_on_bus.len, frame_on_bus.id};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected reply beat: tuser 0x%0h tdata 0x%0h", m_axis_tuser,
                       m_axis_tdata);
                mismatches++;
            end else begin
                head_reply = expected_replies.pop_front();
                check_field("kind", 64'(head_reply.kind), 64'(m_axis_tuser));
                check_field("tx_id", 64'(head_reply.id), 64'(m_axis_tdata[28:0]));
                check_field("tx_len", 64'(head_reply.len), 64'(m_axis_tdata[32:29]));
                check_field("tx_data", head_reply.data, m_axis_tdata[96:33]);
                check_field("last", 64'(head_reply.last), 64'(m_axis_tlast));
            end
        end
    end

    task automatic add_frame(logic [4:0] src, logic [4:0] tgt, logic [2:0] op, logic [15:0] cmd,
                             logic [3:0] len, logic [63:0] data);
        pending_frames.push_back('{{src, tgt, op, cmd}, len, data});
        frames_queued++;
    endtask

    task automatic add_transfer();
        logic [15:0] cmd;
        logic [63:0] data;
        int          last_idx;
        int          end_len;
        int          total;
        int          k;
        cmd = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                          : BLK_BASE + 16'($urandom_range(0, NUM_BLOCKS - 1));
        last_idx = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 7);
        end_len = $urandom_range(0, 15);
        total = (last_idx + 1) * 8 + ((end_len > 8) ? 8 : end_len);
        if ($urandom_range(0, 4) == 0 || total <= 8 || total > 255)
            total = $urandom_range(9, 255);
        data = {$urandom, $urandom};
        data[7:0] = 8'(total);
        add_frame(tool_addr, own_addr, OP_WRITE, cmd, 4'd1, data);
        add_frame(tool_addr, own_addr, OP_START, 16'($urandom), 4'($urandom_range(0, 15)),
                  {$urandom, $urandom});
        for (k = 0; k < last_idx && k < 8; k++)
            if ($urandom_range(0, 5) != 0)
                add_frame(tool_addr, own_addr, OP_XFER, 16'(k),
                          ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd8,
                          {$urandom, $urandom});
        add_frame(tool_addr, own_addr, OP_END, 16'(last_idx), 4'(end_len), {$urandom, $urandom});
    endtask

    task automatic add_random_items(int count);
        int start;
        int pick;
        logic [28:0] id;
        start = frames_queued;
        while (frames_queued - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                add_transfer();
            end else if (pick < 65) begin
                add_frame(5'($urandom), own_addr, OP_READ,
                          ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                      : BLK_BASE + 16'($urandom_range(0, 3)),
                          4'($urandom_range(0, 15)), {$urandom, $urandom});
            end else begin
                id = 29'($urandom);
                if ($urandom_range(0, 1) == 0)
                    id[23:19] = own_addr;
                pending_frames.push_back('{id, 4'($urandom_range(0, 15)), {$urandom, $urandom}});
                frames_queued++;
            end
        end
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [4:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_OWN)
            own_addr = val;
        else
            tool_addr = val;
    endtask

    task automatic wait_idle();
        while (frames_accepted != frames_queued || expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_can_multiframe_parameter_transfer_core: FAIL");
        $finish;
    end

    initial begin
        foreach (param_mem[i])
            param_mem[i] = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_frame(5'd9, own_addr, OP_READ, BLK_BASE, 4'd0, '0);
        add_frame(tool_addr, own_addr, OP_READ, BLK_BASE + 16'd3, 4'd1, '0);
        add_frame(tool_addr, 5'd3, OP_WRITE, BLK_BASE, 4'd1, 64'd64);
        add_frame(tool_addr, own_addr, OP_WRITE, BLK_BASE, 4'd1, 64'd8);
        add_frame(5'd6, own_addr, OP_WRITE, BLK_BASE, 4'd1, 64'd64);
        add_frame(tool_addr, own_addr, OP_WRITE, BLK_BASE + 16'd1, 4'd1, 64'd64);
        add_frame(tool_addr, own_addr, OP_START, 16'hFFFF, 4'd8, 64'h0123_4567_89AB_CDEF);
        add_frame(tool_addr, own_addr, OP_XFER, 16'd0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        add_frame(tool_addr, own_addr, OP_XFER, 16'd7, 4'd8, 64'hDEAD_BEEF_DEAD_BEEF);
        add_frame(tool_addr, own_addr, OP_XFER, 16'hFFFF, 4'd8, 64'hA5A5_A5A5_A5A5_A5A5);
        add_frame(tool_addr, own_addr, OP_END, 16'd6, 4'd8, 64'h1122_3344_5566_7788);
        add_frame(tool_addr, own_addr, OP_READ, BLK_BASE + 16'd1, 4'd8, '0);
        add_frame(tool_addr, own_addr, OP_END, 16'd0, 4'd0, '0);
        add_frame(tool_addr, own_addr, 3'd2, BLK_BASE, 4'd8, '1);
        add_frame(tool_addr, own_addr, 3'd3, BLK_BASE, 4'd8, '1);
        add_frame(tool_addr, own_addr, 3'd7, BLK_BASE, 4'd8, '1);
        add_frame(tool_addr, own_addr, OP_WRITE, 16'h1234, 4'd1, 64'd9);
        add_frame(tool_addr, own_addr, OP_START, 16'd0, 4'd8, 64'hCAFE_F00D_CAFE_F00D);
        add_frame(tool_addr, own_addr, OP_END, 16'd0, 4'd1, 64'h0000_0000_0000_00EE);
        add_frame(tool_addr, own_addr, OP_WRITE, BLK_BASE + 16'd2, 4'd1, 64'd200);
        add_frame(tool_addr, own_addr, OP_START, 16'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        add_frame(tool_addr, own_addr, OP_END, 16'hFFFF, 4'd8, 64'h8000_0000_0000_0001);
        add_frame(tool_addr, own_addr, OP_READ, BLK_BASE + 16'd2, 4'd1, '0);
        add_frame(tool_addr, own_addr, OP_READ, BLK_BASE - 16'd1, 4'd1, '0);
        add_frame(5'd31, 5'd31, 3'd7, 16'hFFFF, 4'd15, '1);
        wait_idle();

        write_cfg(CFG_OWN, 5'd0);
        write_cfg(CFG_TOOL, 5'd31);
        add_random_items(45);
        wait_idle();

        send_idle_pct = 86;
        recv_idle_pct = 36;
        write_cfg(CFG_OWN, 5'd31);
        write_cfg(CFG_TOOL, 5'd0);
        add_random_items(45);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(CFG_OWN, 5'($urandom));
        write_cfg(CFG_TOOL, 5'($urandom));
        add_random_items(40);
        wait_idle();

        if (expected_replies.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("tb_can_multiframe_parameter_transfer_core: PASS");
        else
            $display("tb_can_multiframe_parameter_transfer_core: FAIL");
        $finish;
    end

endmodule
